/* hw/rtl/gha_pkg.sv */
// gha_pkg: shared types for the generational handle allocator
// operation codes and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package gha_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_GET     = 2'd3
    } cmd_t;

    // field widths of the stream words
    localparam int unsigned IDX_W = 8;
    localparam int unsigned GEN_W = 32;

    // controller to datapath
    typedef struct packed {
        logic load;         // capture the input word
        logic stack_rd;     // read top of free stack
        logic tbl_rd;       // read generation table
        logic tbl_sel_pop;  // table address from popped index instead of slot index
        logic commit;       // update state and load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;          // captured operation
        logic free_avail;   // free stack not empty
        logic out_free;     // result register can take a word this cycle
    } ctrl_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/gha_ram.sv */
// gha_ram: generic single write, single read memory with registered read data
// no dependencies
`default_nettype none

module gha_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gha_ctrl.sv */
// gha_ctrl: sequencer for one operation at a time
// depends on gha_pkg (cmd_t, ctrl_cmd_t, ctrl_stat_t)
`default_nettype none

module gha_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire gha_pkg::ctrl_stat_t stat,
    output gha_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DISPATCH = 4'b0010,
        ST_POP      = 4'b0100,
        ST_LOOKUP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.cmd == gha_pkg::CMD_CREATE) begin
                    if (stat.free_avail) begin
                        cmd.stack_rd = 1'b1;
                        state_next   = ST_POP;
                    end else if (stat.out_free) begin
                        // append or table full, no read needed
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.tbl_rd = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_POP: begin
                cmd.tbl_rd      = 1'b1;
                cmd.tbl_sel_pop = 1'b1;
                state_next      = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/gha_datapath.sv */
// gha_datapath: generation table, free stack, counters and result register
// depends on gha_pkg and gha_ram
`default_nettype none

module gha_datapath #(
    parameter int unsigned MAX_SLOTS = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gha_pkg::cmd_t                 in_cmd,
    input  wire logic [gha_pkg::IDX_W-1:0]     in_index,
    input  wire logic [gha_pkg::GEN_W-1:0]     in_generation,
    input  wire gha_pkg::ctrl_cmd_t            cmd,
    output gha_pkg::ctrl_stat_t                stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gha_pkg::IDX_W-1:0]          out_index,
    output logic [gha_pkg::GEN_W-1:0]          out_generation,
    output logic                               out_ok
);

    localparam int unsigned AW    = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int unsigned CMP_W = (CNT_W > gha_pkg::IDX_W) ? CNT_W : gha_pkg::IDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

    // captured input word
    gha_pkg::cmd_t               cmd_reg;
    logic [gha_pkg::IDX_W-1:0]   idx_reg;
    logic [gha_pkg::GEN_W-1:0]   gen_reg;
    logic                        popped_reg;

    // counters
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] slots_reg, slots_next;

    // result register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [gha_pkg::IDX_W-1:0]   res_idx_reg;
    logic [gha_pkg::GEN_W-1:0]   res_gen_reg;
    logic                        res_ok_reg;

    // memory ports
    logic                        tbl_we;
    logic [AW-1:0]               tbl_waddr;
    logic [gha_pkg::GEN_W-1:0]   tbl_wdata;
    logic [AW-1:0]               tbl_raddr;
    logic [gha_pkg::GEN_W-1:0]   tbl_rdata;
    logic                        stk_we;
    logic [gha_pkg::IDX_W-1:0]   stk_rdata;

    // derived values
    logic [CMP_W-1:0]            idx_ext;
    logic [CMP_W-1:0]            slots_ext;
    logic [CMP_W-1:0]            pop_ext;
    logic [CNT_W-1:0]            free_m1;
    logic                        in_range;
    logic                        alive;
    logic [gha_pkg::IDX_W-1:0]   res_idx;
    logic [gha_pkg::GEN_W-1:0]   res_gen;
    logic                        res_ok;

    assign idx_ext   = CMP_W'(idx_reg);
    assign slots_ext = CMP_W'(slots_reg);
    assign pop_ext   = CMP_W'(stk_rdata);
    assign free_m1   = free_count_reg - CNT_W'(1);
    assign in_range  = (idx_ext < slots_ext);
    assign alive     = in_range && (tbl_rdata == gen_reg);
    assign tbl_raddr = cmd.tbl_sel_pop ? pop_ext[AW-1:0] : idx_ext[AW-1:0];

    // generation per slot
    gha_ram #(
        .WIDTH (gha_pkg::GEN_W),
        .DEPTH (MAX_SLOTS)
    ) u_gen_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (cmd.tbl_rd),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    // stack of freed slot indexes
    gha_ram #(
        .WIDTH (gha_pkg::IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_free_stack (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (free_count_reg[AW-1:0]),
        .wr_data (idx_reg),
        .rd_en   (cmd.stack_rd),
        .rd_addr (free_m1[AW-1:0]),
        .rd_data (stk_rdata)
    );

    // operation outcome, applied on commit
    always_comb begin
        res_idx         = '0;
        res_gen         = '0;
        res_ok          = 1'b0;
        tbl_we          = 1'b0;
        tbl_waddr       = idx_ext[AW-1:0];
        tbl_wdata       = tbl_rdata + gha_pkg::GEN_W'(1);
        stk_we          = 1'b0;
        free_count_next = free_count_reg;
        slots_next      = slots_reg;
        case (cmd_reg)
            gha_pkg::CMD_CREATE: begin
                if (popped_reg) begin
                    res_idx         = stk_rdata;
                    res_gen         = tbl_rdata;
                    res_ok          = 1'b1;
                    free_count_next = free_m1;
                end else if (slots_reg != CNT_MAX) begin
                    res_idx    = slots_ext[gha_pkg::IDX_W-1:0];
                    res_gen    = gha_pkg::GEN_W'(1);
                    res_ok     = 1'b1;
                    tbl_we     = cmd.commit;
                    tbl_waddr  = slots_reg[AW-1:0];
                    tbl_wdata  = gha_pkg::GEN_W'(1);
                    slots_next = slots_reg + CNT_W'(1);
                end
            end
            gha_pkg::CMD_DESTROY: begin
                if (alive && (free_count_reg != CNT_MAX)) begin
                    res_ok          = 1'b1;
                    tbl_we          = cmd.commit;
                    stk_we          = cmd.commit;
                    free_count_next = free_count_reg + CNT_W'(1);
                end
            end
            gha_pkg::CMD_CHECK: begin
                res_ok = alive;
            end
            gha_pkg::CMD_GET: begin
                if (in_range) begin
                    res_idx = idx_reg;
                    res_gen = tbl_rdata;
                    res_ok  = 1'b1;
                end
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign m_tvalid_next = cmd.commit | (m_tvalid_reg & ~m_tready);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_count_reg <= '0;
            slots_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            popped_reg     <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.commit) begin
                free_count_reg <= free_count_next;
                slots_reg      <= slots_next;
            end
            if (cmd.load) begin
                popped_reg <= 1'b0;
            end else if (cmd.stack_rd) begin
                popped_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_cmd;
            idx_reg <= in_index;
            gen_reg <= in_generation;
        end
        if (cmd.commit) begin
            res_idx_reg <= res_idx;
            res_gen_reg <= res_gen;
            res_ok_reg  <= res_ok;
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.free_avail = (free_count_reg != '0);
    assign stat.out_free   = ~m_tvalid_reg | m_tready;

    assign m_tvalid       = m_tvalid_reg;
    assign out_index      = res_idx_reg;
    assign out_generation = res_gen_reg;
    assign out_ok         = res_ok_reg;

endmodule

`default_nettype wire

/* hw/rtl/generational_handle_allocator.sv */
// generational_handle_allocator: top level, slot handles of index and generation
// depends on gha_pkg, gha_ctrl, gha_datapath (which holds two gha_ram instances)
//
//   channel | direction | tdata (low bit up)                 | tuser
//   s_      | in        | slot_index[7:0], handle_gen[31:0]   | cmd[1:0]
//   m_      | out       | out_index[7:0], out_gen[31:0], ok   | -
//
// one word is worked at a time: a create that appends or fails commits in dispatch;
// destroy, check and get handle go on to lookup; a create that reuses a freed slot
// adds pop, then lookup, for the registered reads of free stack and generation table.
// reset clears the counters and control only; tables need no clearing pass.
// the result register lets a new word be taken while a result waits on m_tready;
// the following word then waits before its commit until the result is taken.
`default_nettype none

module generational_handle_allocator #(
    parameter int unsigned MAX_SLOTS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // slot_index[7:0], handle_generation[39:8]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // out_index[7:0], out_generation[39:8], ok[40]
);

    gha_pkg::ctrl_cmd_t              cmd;
    gha_pkg::ctrl_stat_t             stat;
    logic [gha_pkg::IDX_W-1:0]       out_index;
    logic [gha_pkg::GEN_W-1:0]       out_generation;
    logic                            out_ok;

    // sequencer
    gha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // tables, counters and result
    gha_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_cmd         (gha_pkg::cmd_t'(s_tuser)),
        .in_index       (s_tdata[7:0]),
        .in_generation  (s_tdata[39:8]),
        .cmd            (cmd),
        .stat           (stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_index      (out_index),
        .out_generation (out_generation),
        .out_ok         (out_ok)
    );

    // pack result word
    assign m_tdata = {7'd0, out_ok, out_generation, out_index};

endmodule

`default_nettype wire
